@@ rtl/nbq_pkg.sv @@
// package for the n-best score queue: sizes, codes and request/result types
`timescale 1ns / 1ps

package nbq_pkg;

    localparam int DEPTH_N = 16;
    localparam int IDX_W   = (DEPTH_N > 1) ? $clog2(DEPTH_N) : 1;
    localparam int CNT_W   = $clog2(DEPTH_N + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_POPPED   = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [31:0] score;
        logic [31:0] payload;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_score;
        logic [31:0] out_payload;
        logic [4:0]  occupancy;
    } rsp_t;

endpackage

@@ rtl/n_best_score_queue_unit.sv @@
// n-best score queue: slot store, one-pass scanner and control sequencer
// insert into a non-full store: result strobe in the cycle after the request, busy stays low
// replacing insert or pop: one scan pass through S_SCAN, then one S_FINISH state,
// with the result strobe registered out of S_FINISH
// dropped insert or pop of an empty store: result strobe in the cycle after the request
// throughput: one request per cycle without a scan; a scan holds busy high until it ends;
// the receiver cannot stall. reset clears valid bits, count and worst mark, not slot contents
`timescale 1ns / 1ps

module n_best_score_queue_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  nbq_pkg::req_t request,
    output logic          done,
    output nbq_pkg::rsp_t result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;

    logic [31:0] score_mem   [nbq_pkg::DEPTH_N];
    logic [31:0] payload_mem [nbq_pkg::DEPTH_N];

    logic [nbq_pkg::DEPTH_N-1:0] valid_reg;
    logic [nbq_pkg::CNT_W-1:0]   count_reg;
    logic [31:0]                 worst_score_reg;
    logic [nbq_pkg::IDX_W-1:0]   worst_slot_reg;
    logic                        op_reg;
    logic [nbq_pkg::CNT_W-1:0]   step_reg;
    logic                        done_reg;
    nbq_pkg::rsp_t               result_reg;

    // scan trackers
    logic                      max_found_reg;
    logic [31:0]               max_score_reg;
    logic [31:0]               max_payload_reg;
    logic [nbq_pkg::IDX_W-1:0] max_idx_reg;
    logic                      min_found_reg;
    logic [31:0]               min_score_reg;
    logic [nbq_pkg::IDX_W-1:0] min_idx_reg;

    logic [31:0] rd_score_reg;
    logic [31:0] rd_payload_reg;

    logic                      accept;
    logic                      is_full;
    logic [nbq_pkg::IDX_W-1:0] free_slot;
    logic [nbq_pkg::CNT_W-1:0] count_inc;
    logic [nbq_pkg::CNT_W-1:0] count_dec;
    logic [nbq_pkg::CNT_W-1:0] prev_step;
    logic [nbq_pkg::IDX_W-1:0] cmp_idx;
    logic                      cmp_live;
    logic [nbq_pkg::IDX_W-1:0] rd_addr;
    logic                      mem_we;
    logic [nbq_pkg::IDX_W-1:0] wr_addr;
    logic                      done_next;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign is_full   = (count_reg == nbq_pkg::CNT_W'(nbq_pkg::DEPTH_N));
    assign count_inc = count_reg + nbq_pkg::CNT_W'(1);
    assign count_dec = count_reg - nbq_pkg::CNT_W'(1);
    assign prev_step = step_reg - nbq_pkg::CNT_W'(1);
    assign cmp_idx   = prev_step[nbq_pkg::IDX_W-1:0];
    assign cmp_live  = valid_reg[cmp_idx];
    assign done      = done_reg;
    assign result    = result_reg;

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = nbq_pkg::DEPTH_N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = nbq_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        wr_addr   = free_slot;
        done_next = 1'b0;
        if (accept)
        begin
            if (request.opcode == nbq_pkg::OP_INSERT)
            begin
                if (!is_full)
                begin
                    mem_we    = 1'b1;
                    done_next = 1'b1;
                end
                else if (request.score > worst_score_reg)
                begin
                    mem_we  = 1'b1;
                    wr_addr = worst_slot_reg;
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
            else if (count_reg == '0)
            begin
                done_next = 1'b1;
            end
        end
        if (state_reg == S_FINISH)
        begin
            done_next = 1'b1;
        end
        if (step_reg < nbq_pkg::CNT_W'(nbq_pkg::DEPTH_N))
        begin
            rd_addr = step_reg[nbq_pkg::IDX_W-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            score_mem[wr_addr]   <= request.score;
            payload_mem[wr_addr] <= request.payload;
        end
        rd_score_reg   <= score_mem[rd_addr];
        rd_payload_reg <= payload_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            count_reg       <= '0;
            worst_score_reg <= '0;
            worst_slot_reg  <= '0;
            op_reg          <= nbq_pkg::OP_INSERT;
            step_reg        <= '0;
            done_reg        <= 1'b0;
            result_reg      <= '0;
            max_found_reg   <= 1'b0;
            max_score_reg   <= '0;
            max_payload_reg <= '0;
            max_idx_reg     <= '0;
            min_found_reg   <= 1'b0;
            min_score_reg   <= '0;
            min_idx_reg     <= '0;
        end
        else
        begin
            done_reg <= done_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg        <= request.opcode;
                        step_reg      <= '0;
                        max_found_reg <= 1'b0;
                        min_found_reg <= 1'b0;
                        if (request.opcode == nbq_pkg::OP_INSERT)
                        begin
                            if (!is_full)
                            begin
                                valid_reg[free_slot] <= 1'b1;
                                count_reg            <= count_inc;
                                if (count_reg == '0 || request.score < worst_score_reg)
                                begin
                                    worst_score_reg <= request.score;
                                    worst_slot_reg  <= free_slot;
                                end
                                result_reg <= '{nbq_pkg::ST_INSERTED, 32'd0, 32'd0,
                                                5'(count_inc)};
                            end
                            else if (request.score > worst_score_reg)
                            begin
                                state_reg <= S_SCAN;
                            end
                            else
                            begin
                                result_reg <= '{nbq_pkg::ST_DROPPED, 32'd0, 32'd0,
                                                5'(count_reg)};
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            result_reg <= '{nbq_pkg::ST_EMPTY, 32'd0, 32'd0, 5'(count_reg)};
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    step_reg <= step_reg + nbq_pkg::CNT_W'(1);
                    // read data is registered, so the slot compared is the one addressed at the previous step
                    if (step_reg != '0 && cmp_live)
                    begin
                        if (!max_found_reg || rd_score_reg >= max_score_reg)
                        begin
                            max_found_reg   <= 1'b1;
                            max_score_reg   <= rd_score_reg;
                            max_payload_reg <= rd_payload_reg;
                            max_idx_reg     <= cmp_idx;
                        end
                        if (!min_found_reg || rd_score_reg < min_score_reg)
                        begin
                            min_found_reg <= 1'b1;
                            min_score_reg <= rd_score_reg;
                            min_idx_reg   <= cmp_idx;
                        end
                    end
                    if (step_reg == nbq_pkg::CNT_W'(nbq_pkg::DEPTH_N))
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    state_reg <= S_IDLE;
                    if (op_reg == nbq_pkg::OP_POP)
                    begin
                        valid_reg[max_idx_reg] <= 1'b0;
                        count_reg              <= count_dec;
                        // min and max land on one slot only when it was the last entry
                        if (min_found_reg && min_idx_reg != max_idx_reg)
                        begin
                            worst_score_reg <= min_score_reg;
                            worst_slot_reg  <= min_idx_reg;
                        end
                        else
                        begin
                            worst_score_reg <= '0;
                            worst_slot_reg  <= '0;
                        end
                        result_reg <= '{nbq_pkg::ST_POPPED, max_score_reg, max_payload_reg,
                                        5'(count_dec)};
                    end
                    else
                    begin
                        worst_score_reg <= min_score_reg;
                        worst_slot_reg  <= min_idx_reg;
                        result_reg      <= '{nbq_pkg::ST_REPLACED, 32'd0, 32'd0,
                                             5'(count_reg)};
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
